/* hw/rtl/olte_pkg.sv */
// Shared types and codes for the ordered list table engine.
`timescale 1ns / 1ps
`default_nettype none

package olte_pkg;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_LOCATE = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_RANGE    = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [5:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [5:0]         found_position;
		logic [5:0]         count_after;
	} rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/olte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module olte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ordered_list_table_engine_core.sv */
// Ordered list table engine: top level with walk sequencer over the entry RAM.
//
//  channel   | handshake          | payload | direction
//  ----------+--------------------+---------+----------
//  request   | start / busy       | req     | in
//  response  | done (1-cycle)     | rsp     | out
//
// Rejected requests, kind 3 and locate on an empty list finish without raising busy;
// the response strobes the cycle after the transfer.
// Insert shifts entries from the tail down to p, then writes p; an append only writes.
// Delete shifts entries down from p to the tail. Locate stops at the first match.
// The walk moves one entry per cycle through the single read port of the entry RAM.
// Reset clears count and control only; entry contents are never read before written.
// Responses cannot be stalled; a new request may be transferred while done is high.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_table_engine_core
	import olte_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output      logic busy,
	input  wire req_t req,
	output      logic done,
	output      rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 6) ? CW : 6;
	localparam int EW = PW + 1;

	state_t state_q, state_d;

	logic [CW-1:0]      cnt_q, cnt_d;
	logic [1:0]         kind_q;
	logic [AW-1:0]      pos_q;
	logic signed [31:0] val_q;
	logic [AW-1:0]      ra_q, la_q;
	logic               iss_q;
	logic               rv_s1;
	logic [AW-1:0]      rad_s1;
	logic signed [31:0] removed_q;
	logic               done_q;
	rsp_t               rsp_q, rsp_d;

	logic               acc, fin;
	logic               re, we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata, rdata;

	logic [EW-1:0]      pos_e, cnt_e;
	logic               ins_bad, del_bad, full;
	logic [AW-1:0]      pm1, cm1;
	logic               last_s1;
	logic [PW-1:0]      cnt_x, fnd_x;

	assign busy  = (state_q != ST_IDLE);
	assign acc   = start && !busy;
	assign done  = done_q;
	assign rsp   = rsp_q;

	assign pos_e   = EW'(req.position);
	assign cnt_e   = EW'(cnt_q);
	assign ins_bad = (req.position == 6'd0) || (pos_e > cnt_e + EW'(1));
	assign del_bad = (req.position == 6'd0) || (pos_e > cnt_e);
	assign full    = (cnt_q == CW'(CAPACITY));
	assign pm1     = AW'(pos_e - EW'(1));
	assign cm1     = AW'(cnt_e - EW'(1));
	assign last_s1 = (rad_s1 == la_q);
	assign cnt_x   = PW'(cnt_d);
	assign fnd_x   = PW'(rad_s1) + PW'(1);

	olte_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(ra_q),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (req.kind)
						KIND_INSERT: begin
							if (!ins_bad && !full) begin
								state_d = (pos_e == cnt_e + EW'(1)) ? ST_PUT : ST_SCAN;
							end
						end
						KIND_DELETE: begin
							if (!del_bad) state_d = ST_SCAN;
						end
						KIND_LOCATE: begin
							if (cnt_q != '0) state_d = ST_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (fin) begin
					state_d = ST_IDLE;
				end else if (rv_s1 && last_s1 && kind_q == KIND_INSERT) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control and response
	always_comb begin
		fin                   = 1'b0;
		we                    = 1'b0;
		waddr                 = rad_s1;
		wdata                 = rdata;
		cnt_d                 = cnt_q;
		rsp_d.status          = STAT_OK;
		rsp_d.removed_value   = '0;
		rsp_d.found_position  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (req.kind)
						KIND_INSERT: begin
							if (ins_bad) begin
								fin          = 1'b1;
								rsp_d.status = STAT_RANGE;
							end else if (full) begin
								fin          = 1'b1;
								rsp_d.status = STAT_FULL;
							end
						end
						KIND_DELETE: begin
							if (del_bad) begin
								fin          = 1'b1;
								rsp_d.status = STAT_RANGE;
							end
						end
						KIND_LOCATE: begin
							if (cnt_q == '0) begin
								fin          = 1'b1;
								rsp_d.status = STAT_NOTFOUND;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				if (rv_s1) begin
					case (kind_q)
						KIND_INSERT: begin
							we    = 1'b1;
							waddr = rad_s1 + AW'(1);
						end
						KIND_DELETE: begin
							if (rad_s1 != pos_q) begin
								we    = 1'b1;
								waddr = rad_s1 - AW'(1);
							end
							if (last_s1) begin
								fin                 = 1'b1;
								cnt_d               = cnt_q - CW'(1);
								rsp_d.removed_value = (rad_s1 == pos_q) ? $signed(rdata)
								                                        : removed_q;
							end
						end
						default: begin
							if ($signed(rdata) == val_q) begin
								fin                  = 1'b1;
								rsp_d.found_position = fnd_x[5:0];
							end else if (last_s1) begin
								fin          = 1'b1;
								rsp_d.status = STAT_NOTFOUND;
							end
						end
					endcase
				end
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = val_q;
				fin   = 1'b1;
				cnt_d = cnt_q + CW'(1);
			end
			default: fin = 1'b0;
		endcase
		rsp_d.count_after = cnt_x[5:0];
	end

	assign re = (state_q == ST_SCAN) && iss_q && !fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iss_q   <= 1'b0;
			rv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rv_s1   <= re;
			done_q  <= fin;
			if (acc) begin
				iss_q <= 1'b1;
			end else if (re) begin
				iss_q <= (ra_q != la_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= req.kind;
			val_q  <= req.value;
			pos_q  <= pm1;
			unique case (req.kind)
				KIND_INSERT: begin
					ra_q <= cm1;
					la_q <= pm1;
				end
				KIND_DELETE: begin
					ra_q <= pm1;
					la_q <= cm1;
				end
				default: begin
					ra_q <= '0;
					la_q <= cm1;
				end
			endcase
		end else if (re) begin
			// insert walks down from the tail, delete and locate walk up
			ra_q <= (kind_q == KIND_INSERT) ? ra_q - AW'(1) : ra_q + AW'(1);
		end
		if (re) begin
			rad_s1 <= ra_q;
		end
		if (state_q == ST_SCAN && rv_s1 && kind_q == KIND_DELETE && rad_s1 == pos_q) begin
			removed_q <= $signed(rdata);
		end
		if (fin) begin
			rsp_q <= rsp_d;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response strobe while walk in progress");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_rv_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> $past(state_q == ST_SCAN))
		else $error("read data valid outside a walk");

	a_cnt_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> done)
		else $error("entry count changed without a response");

	a_put_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |-> (we && fin))
		else $error("insert slot not written on finish");

endmodule

`default_nettype wire

/* verif/olte_response_checker.sv */
// Response checker for the ordered list table engine: shadow list model and in-order compare.
`timescale 1ns / 1ps

module olte_response_checker
	import olte_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   outstanding,
	output int   checked
);

	logic [31:0] list_words [CAPACITY];
	int          list_len;
	rsp_t        expected_rsps [$];
	int          mismatches;
	int          matched;

	// Applies one request to the shadow list and returns the response it should produce.
	task automatic predict_response(input req_t r, output rsp_t o);
		int k;
		int p;
		o = '0;
		p = r.position;
		case (r.kind)
			KIND_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					o.status = STAT_RANGE;
				end else if (list_len >= CAPACITY) begin
					o.status = STAT_FULL;
				end else begin
					for (k = list_len; k >= p; k--)
						list_words[k] = list_words[k - 1];
					list_words[p - 1] = r.value;
					list_len++;
				end
			end
			KIND_DELETE: begin
				if (p < 1 || p > list_len) begin
					o.status = STAT_RANGE;
				end else begin
					o.removed_value = list_words[p - 1];
					for (k = p; k < list_len; k++)
						list_words[k - 1] = list_words[k];
					list_len--;
				end
			end
			KIND_LOCATE: begin
				o.status = STAT_NOTFOUND;
				for (k = 0; k < list_len; k++) begin
					if (list_words[k] == r.value) begin
						o.status         = STAT_OK;
						o.found_position = 6'(k + 1);
						break;
					end
				end
			end
			default: begin
				// unused kind: no change, status ok, zero value and position fields
			end
		endcase
		o.count_after = 6'(list_len);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : sample
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			list_len = 0;
			expected_rsps.delete();
		end else begin
			// the response to a transfer never comes at the same edge, so pop first
			if (done) begin
				got = rsp;
				if (expected_rsps.size() == 0) begin
					$display("%0t ns: response expected none, got %h", $time, got);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("removed_value", want.removed_value, got.removed_value);
					check_field("found_position", 32'(want.found_position),
						32'(got.found_position));
					check_field("count_after", 32'(want.count_after), 32'(got.count_after));
					matched++;
				end
			end
			if (start && !busy) begin
				predict_response(req, want);
				expected_rsps.push_back(want);
			end
		end
		outstanding <= expected_rsps.size();
		fail_count  <= mismatches;
		checked     <= matched;
	end

endmodule

/* verif/ordered_list_table_engine_core_tb.sv */
// Testbench top for the ordered list table engine: request stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module ordered_list_table_engine_core_tb;
	import olte_pkg::*;

	localparam int         CAPACITY      = 32;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;
	localparam int         ITEM_TARGET   = 1200;
	localparam int         QUIET_LIMIT   = 1000;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         RECENT_DEPTH  = 16;

	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_EVEN
	} mix_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int checked;

	// stimulus-side view of list length, used to aim positions and count full-list inserts
	int          shadow_len;
	logic [31:0] recent_values [$];
	int          sent;
	int          per_kind [4];
	int          full_hits;
	int          burst_left;

	ordered_list_table_engine_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	olte_response_checker #(
		.CAPACITY(CAPACITY)
	) rsp_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.fail_count (fail_count),
		.outstanding(outstanding),
		.checked    (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_req(input logic [1:0] kind, input logic [5:0] pos,
			input logic [31:0] val);
		req_t r;
		int   p;
		r.kind     = kind;
		r.position = pos;
		r.value    = val;
		p          = pos;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		per_kind[kind]++;
		if (kind == KIND_INSERT && p >= 1 && p <= shadow_len + 1) begin
			if (shadow_len >= CAPACITY) begin
				full_hits++;
			end else begin
				shadow_len++;
				recent_values.push_back(val);
				if (recent_values.size() > RECENT_DEPTH)
					void'(recent_values.pop_front());
			end
		end else if (kind == KIND_DELETE && p >= 1 && p <= shadow_len) begin
			shadow_len--;
		end
	endtask

	task automatic pause_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every transfer has its response back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic after_item();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0)
				pause_cycles(gap);
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(1, 16);
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hffff_ffff;
					2: return 32'h7fff_ffff;
					default: return 32'h8000_0000;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random(input mix_t mix);
		int          roll;
		int          ins_cut;
		int          del_cut;
		logic [31:0] v;
		case (mix)
			MIX_GROW: begin
				ins_cut = 75;
				del_cut = 85;
			end
			MIX_SHRINK: begin
				ins_cut = 15;
				del_cut = 75;
			end
			default: begin
				ins_cut = 35;
				del_cut = 65;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_cut) begin
			// top slot on a full list lands on the full case
			send_req(KIND_INSERT, 6'($urandom_range(1, shadow_len + 1)), pick_value());
		end else if (roll < del_cut) begin
			send_req(KIND_DELETE, 6'($urandom_range(1, shadow_len > 0 ? shadow_len : 1)),
				$urandom());
		end else if (roll < 95) begin
			if (recent_values.size() > 0 && $urandom_range(0, 1) == 1)
				v = recent_values[$urandom_range(0, recent_values.size() - 1)];
			else
				v = pick_value();
			send_req(KIND_LOCATE, 6'($urandom_range(0, 63)), v);
		end else begin
			send_req(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), $urandom());
		end
	endtask

	initial begin : stimulus
		int   round;
		int   round_len;
		mix_t mix;
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		burst_left = 4;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, range errors, edges of the list, extreme values
		send_req(KIND_LOCATE, 6'd0, 32'h0000_0000); after_item();
		send_req(KIND_DELETE, 6'd1, 32'h0000_0000); after_item();
		send_req(KIND_INSERT, 6'd0, 32'h0000_0001); after_item();
		send_req(KIND_INSERT, 6'd2, 32'h0000_0001); after_item();
		send_req(KIND_INSERT, 6'd1, 32'h7fff_ffff); after_item();
		send_req(KIND_INSERT, 6'd1, 32'h8000_0000); after_item();
		send_req(KIND_INSERT, 6'd3, 32'h0000_0000); after_item();
		send_req(KIND_INSERT, 6'd2, 32'hffff_ffff); after_item();
		send_req(KIND_INSERT, 6'd63, 32'h0000_0005); after_item();
		send_req(KIND_LOCATE, 6'd63, 32'h8000_0000); after_item();
		send_req(KIND_LOCATE, 6'd0, 32'h7fff_ffff); after_item();
		send_req(KIND_LOCATE, 6'd17, 32'h0000_0000); after_item();
		send_req(KIND_LOCATE, 6'd1, 32'h0000_3039); after_item();
		send_req(KIND_INSERT, 6'd5, 32'h0000_0000); after_item();
		send_req(KIND_LOCATE, 6'd2, 32'h0000_0000); after_item();
		send_req(KIND_UNUSED, 6'd63, 32'hffff_ffff); after_item();
		send_req(KIND_DELETE, 6'd0, 32'h0000_0000); after_item();
		send_req(KIND_DELETE, 6'd6, 32'h0000_0000); after_item();
		send_req(KIND_DELETE, 6'd5, 32'h0000_0000); after_item();
		send_req(KIND_DELETE, 6'd1, 32'h0000_0000); after_item();
		send_req(KIND_DELETE, 6'd2, 32'h0000_0000); after_item();
		send_req(KIND_DELETE, 6'd1, 32'h0000_0000); after_item();
		send_req(KIND_DELETE, 6'd1, 32'h0000_0000); after_item();
		send_req(KIND_LOCATE, 6'd1, 32'hffff_ffff); after_item();
		drain();

		// random rounds: fill up first, then empty out, then mixed
		round = 0;
		while (sent < ITEM_TARGET) begin
			round_len = $urandom_range(60, 140);
			if (round == 0)
				mix = MIX_GROW;
			else if (round == 1)
				mix = MIX_SHRINK;
			else
				mix = mix_t'($urandom_range(0, 2));
			repeat (round_len) begin
				send_random(mix);
				after_item();
			end
			round++;
			if (round % 4 == 0)
				drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d requests: %0d insert, %0d delete, %0d locate, %0d unused.",
			sent, per_kind[KIND_INSERT], per_kind[KIND_DELETE], per_kind[KIND_LOCATE],
			per_kind[KIND_UNUSED]);
		$display("%0d responses compared; %0d inserts were against a full list.",
			checked, full_hits);
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ends the run if neither a request nor a response transfer happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* ordered_list_table_engine_core.f */
hw/rtl/olte_pkg.sv
hw/rtl/olte_ram.sv
hw/rtl/ordered_list_table_engine_core.sv
verif/olte_response_checker.sv
verif/ordered_list_table_engine_core_tb.sv
